/* src/srs_pkg.sv */
// shared constants, types and helpers for the stripe request splitter
package srs_pkg;

    localparam int BLOCK_BITS  = 16;
    localparam int BLOCK_SIZE  = 1 << BLOCK_BITS;
    localparam int MAX_DEVICES = 16;
    localparam int MAX_CHUNKS  = 64;

    localparam int OFFSET_W    = 48;
    localparam int LENGTH_W    = 22;
    localparam int DEV_CNT_W   = 5;
    localparam int DEV_IDX_W   = 4;
    localparam int CHUNK_LEN_W = 17;
    localparam int BLOCK_NUM_W = OFFSET_W - BLOCK_BITS;
    localparam int DIV_CNT_W   = $clog2(BLOCK_NUM_W);

    localparam logic [LENGTH_W-1:0]    LEN_BOUND =
        LENGTH_W'((MAX_CHUNKS - 1) * BLOCK_SIZE);
    localparam logic [CHUNK_LEN_W-1:0] BLOCK_LEN = CHUNK_LEN_W'(BLOCK_SIZE);
    localparam logic [DEV_CNT_W-1:0]   DEV_MAX   = DEV_CNT_W'(MAX_DEVICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHUNK,
        ST_ERR
    } split_state_t;

    typedef struct packed {
        logic                   start;
        logic [BLOCK_NUM_W-1:0] dividend;
        logic [DEV_CNT_W-1:0]   divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                   done;
        logic [BLOCK_NUM_W-1:0] quotient;
        logic [DEV_IDX_W-1:0]   remainder;
    } div_result_t;

    function automatic logic [DEV_CNT_W-1:0] eff_devices(input logic [DEV_CNT_W-1:0] cnt);
        logic [DEV_CNT_W-1:0] d;
        d = cnt;
        if (d == '0)
        begin
            d = DEV_CNT_W'(1);
        end
        if (d > DEV_MAX)
        begin
            d = DEV_MAX;
        end
        return d;
    endfunction

endpackage

/* src/srs_req_if.sv */
// request channel: start position and length of a logical byte request
interface srs_req_if import srs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] start_offset;
    logic [LENGTH_W-1:0] length;

    modport source (output valid, output start_offset, output length, input ready);
    modport sink   (input valid, input start_offset, input length, output ready);
endinterface

/* src/srs_chunk_if.sv */
// chunk channel: one mapped piece of a request per transfer
interface srs_chunk_if import srs_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [DEV_IDX_W-1:0]   device_index;
    logic [OFFSET_W-1:0]    device_offset;
    logic [CHUNK_LEN_W-1:0] chunk_length;
    logic [LENGTH_W-1:0]    request_offset;
    logic                   last_chunk;
    logic                   error;

    modport source (output valid, output device_index, output device_offset,
                    output chunk_length, output request_offset, output last_chunk,
                    output error, input ready);
    modport sink   (input valid, input device_index, input device_offset,
                    input chunk_length, input request_offset, input last_chunk,
                    input error, output ready);
endinterface

/* src/srs_cfg_if.sv */
// configuration write channel carrying the device count
interface srs_cfg_if import srs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [DEV_CNT_W-1:0] device_count;

    modport source (output valid, output device_count, input ready);
    modport sink   (input valid, input device_count, output ready);
endinterface

/* src/srs_divider.sv */
// radix-2 restoring divider: block number by device count, one bit per cycle
module srs_divider import srs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_cmd_t    cmd,
    output div_result_t res
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BLOCK_NUM_W-1:0] dvd_reg, dvd_next;
    logic [DEV_IDX_W-1:0]   rem_reg, rem_next;
    logic [DEV_CNT_W-1:0]   dsr_reg, dsr_next;

    logic [DEV_CNT_W-1:0]   trial;
    logic [DEV_CNT_W-1:0]   diff;
    logic                   fits;

    assign trial = {rem_reg, dvd_reg[BLOCK_NUM_W-1]};
    assign fits  = (trial >= dsr_reg);
    assign diff  = trial - dsr_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = cmd.dividend;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[BLOCK_NUM_W-2:0], fits};
            rem_next = fits ? diff[DEV_IDX_W-1:0] : trial[DEV_IDX_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(BLOCK_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = dvd_reg;
    assign res.remainder = rem_reg;

endmodule

/* src/stripe_request_splitter.sv */
// top level: splits a striped-volume byte request into per-block chunks
//
// channels: cfg writes the device count (0 acts as 1, above 16 acts as 16);
// req carries start_offset and length; chunk returns one result per stripe
// block touched, in ascending logical order, with last_chunk on the final one.
// a zero-length request gives no result; a length above 63 blocks gives one
// result with error set and all other fields zero.
// timing: req is taken only while idle. a valid request first passes through the
// bit-serial divider (32 quotient bits of the block number), whose quotient and
// remainder give the starting row and device; the block then offers one chunk
// per cycle while the receiver takes them.
// an error request offers its result in the cycle after acceptance; a
// zero-length request leaves the block ready in the next cycle.
// reset: device count returns to 1, the sequencer goes idle, no chunk pending.
// stalls: while chunk.ready is low the current chunk holds and the walk waits.
module stripe_request_splitter import srs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    srs_cfg_if.sink     cfg,
    srs_req_if.sink     req,
    srs_chunk_if.source chunk
);

    split_state_t           state_reg, state_next;
    logic [DEV_CNT_W-1:0]   dev_cnt_reg;
    logic [DEV_CNT_W-1:0]   devs_reg, devs_next;
    logic [DEV_IDX_W-1:0]   device_reg, device_next;
    logic [BLOCK_NUM_W-1:0] row_reg, row_next;
    logic [BLOCK_BITS-1:0]  in_block_reg, in_block_next;
    logic [LENGTH_W-1:0]    left_reg, left_next;
    logic [LENGTH_W-1:0]    done_reg, done_next;

    div_cmd_t               div_cmd;
    div_result_t            div_res;

    logic                   req_fire;
    logic                   chunk_fire;
    logic                   len_zero;
    logic                   len_over;
    logic [CHUNK_LEN_W-1:0] room;
    logic [CHUNK_LEN_W-1:0] take;
    logic                   is_last;
    logic                   dev_wrap;

    assign req_fire   = req.valid && req.ready;
    assign chunk_fire = chunk.valid && chunk.ready;
    assign len_zero   = (req.length == '0);
    assign len_over   = (req.length > LEN_BOUND);

    // bytes to the end of the current block, capped by what is left
    assign room     = BLOCK_LEN - {1'b0, in_block_reg};
    assign is_last  = ({{(LENGTH_W-CHUNK_LEN_W){1'b0}}, room} >= left_reg);
    assign take     = is_last ? left_reg[CHUNK_LEN_W-1:0] : room;
    assign dev_wrap = (({1'b0, device_reg} + DEV_CNT_W'(1)) == devs_reg);

    srs_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .res   (div_res)
    );

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_cnt_reg <= DEV_CNT_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            dev_cnt_reg <= cfg.device_count;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && !len_zero)
                begin
                    state_next = len_over ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_CHUNK;
                end
            end
            ST_CHUNK:
            begin
                if (chunk_fire && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (chunk_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready            = 1'b0;
        chunk.valid          = 1'b0;
        chunk.device_index   = '0;
        chunk.device_offset  = '0;
        chunk.chunk_length   = '0;
        chunk.request_offset = '0;
        chunk.last_chunk     = 1'b0;
        chunk.error          = 1'b0;
        div_cmd.start        = 1'b0;
        div_cmd.dividend     = req.start_offset[OFFSET_W-1:BLOCK_BITS];
        div_cmd.divisor      = eff_devices(dev_cnt_reg);
        case (state_reg)
            ST_IDLE:
            begin
                req.ready     = 1'b1;
                div_cmd.start = req_fire && !len_zero && !len_over;
            end
            ST_DIV:
            begin
            end
            ST_CHUNK:
            begin
                chunk.valid          = 1'b1;
                chunk.device_index   = device_reg;
                chunk.device_offset  = {row_reg, in_block_reg};
                chunk.chunk_length   = take;
                chunk.request_offset = done_reg;
                chunk.last_chunk     = is_last;
            end
            ST_ERR:
            begin
                chunk.valid = 1'b1;
                chunk.error = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        devs_next     = devs_reg;
        device_next   = device_reg;
        row_next      = row_reg;
        in_block_next = in_block_reg;
        left_next     = left_reg;
        done_next     = done_reg;
        if (state_reg == ST_IDLE && req_fire)
        begin
            devs_next     = eff_devices(dev_cnt_reg);
            in_block_next = req.start_offset[BLOCK_BITS-1:0];
            left_next     = req.length;
            done_next     = '0;
        end
        if (state_reg == ST_DIV && div_res.done)
        begin
            device_next = div_res.remainder;
            row_next    = div_res.quotient;
        end
        if (state_reg == ST_CHUNK && chunk_fire)
        begin
            in_block_next = '0;
            left_next     = left_reg - {{(LENGTH_W-CHUNK_LEN_W){1'b0}}, take};
            done_next     = done_reg + {{(LENGTH_W-CHUNK_LEN_W){1'b0}}, take};
            if (dev_wrap)
            begin
                device_next = '0;
                row_next    = row_reg + BLOCK_NUM_W'(1);
            end
            else
            begin
                device_next = device_reg + DEV_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        devs_reg     <= devs_next;
        device_reg   <= device_next;
        row_reg      <= row_next;
        in_block_reg <= in_block_next;
        left_reg     <= left_next;
        done_reg     <= done_next;
    end

    // checks
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && chunk.valid))
        else $error("request taken while a chunk is pending");

    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk.valid && !chunk.error) |-> (chunk.chunk_length != '0))
        else $error("empty chunk offered");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk_fire && (chunk.last_chunk || chunk.error)) |=> req.ready)
        else $error("sequencer not idle after final result");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide phase");

    a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHUNK) |-> ({1'b0, device_reg} < devs_reg))
        else $error("device index beyond device count");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the stripe request splitter: random requests, predicted chunks
`timescale 1ns / 1ps

module testbench;
    import srs_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [OFFSET_W-1:0] start_offset;
        logic [LENGTH_W-1:0] length;
    } request_t;

    typedef struct packed {
        logic [DEV_IDX_W-1:0]   device_index;
        logic [OFFSET_W-1:0]    device_offset;
        logic [CHUNK_LEN_W-1:0] chunk_length;
        logic [LENGTH_W-1:0]    request_offset;
        logic                   last_chunk;
        logic                   error;
    } chunk_t;

    logic clk;
    logic rst_n;

    srs_cfg_if   cfg_ch();
    srs_req_if   req_ch();
    srs_chunk_if chunk_ch();

    stripe_request_splitter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .chunk (chunk_ch)
    );

    request_t             pending_requests[$];
    chunk_t               expected_chunks[$];
    logic [DEV_CNT_W-1:0] device_count_cfg;
    logic                 request_taken;
    int                   request_gap;
    int                   chunk_stall;
    bit                   steady;
    int                   mismatches = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // append one request to the driver queue
    task automatic queue_request(input logic [OFFSET_W-1:0] start,
                                 input logic [LENGTH_W-1:0] len);
        request_t r;
        r.start_offset   = start;
        r.length         = len;
        pending_requests = {pending_requests, r};
    endtask

    // walk the stripe blocks touched by one request
    task automatic split_request(input logic [OFFSET_W-1:0] start, input logic [LENGTH_W-1:0] len);
        logic [63:0] devs;
        logic [63:0] pos;
        logic [63:0] block;
        logic [63:0] left;
        logic [63:0] done;
        logic [63:0] in_blk;
        logic [63:0] take;
        chunk_t      c;
        int          n;
        devs = 64'(device_count_cfg);
        if (devs == 0)
        begin
            devs = 1;
        end
        if (devs > MAX_DEVICES)
        begin
            devs = MAX_DEVICES;
        end
        if (len == '0)
        begin
            return;
        end
        if (len > LEN_BOUND)
        begin
            c = '0;
            c.error = 1'b1;
            expected_chunks = {expected_chunks, c};
            return;
        end
        pos   = 64'(start);
        block = pos >> BLOCK_BITS;
        left  = 64'(len);
        done  = 0;
        n     = 0;
        while (left != 0 && n < MAX_CHUNKS)
        begin
            in_blk = pos % 64'(BLOCK_SIZE);
            take = 64'(BLOCK_SIZE) - in_blk;
            if (take > left)
            begin
                take = left;
            end
            c.device_index   = DEV_IDX_W'(block % devs);
            c.device_offset  = OFFSET_W'((block / devs) * 64'(BLOCK_SIZE) + in_blk);
            c.chunk_length   = CHUNK_LEN_W'(take);
            c.request_offset = LENGTH_W'(done);
            c.last_chunk     = (take == left);
            c.error          = 1'b0;
            expected_chunks = {expected_chunks, c};
            left  = left - take;
            done  = done + take;
            pos   = pos + take;
            block = block + 1;
            n++;
        end
    endtask

    function automatic logic [OFFSET_W-1:0] random_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            return {16'($urandom), 32'($urandom)};
        end
        if (r < 65)
        begin
            return (OFFSET_W'($urandom_range(0, 300)) << BLOCK_BITS) | OFFSET_W'(16'($urandom));
        end
        if (r < 80)
        begin
            return (OFFSET_W'($urandom_range(1, 5000)) << BLOCK_BITS)
                   - OFFSET_W'($urandom_range(0, 16));
        end
        return {OFFSET_W{1'b1}} - OFFSET_W'($urandom_range(0, 4200000));
    endfunction

    function automatic logic [LENGTH_W-1:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return '0;
        end
        if (r < 10)
        begin
            return LENGTH_W'($urandom_range(int'(LEN_BOUND) + 1, (1 << LENGTH_W) - 1));
        end
        if (r < 13)
        begin
            return LEN_BOUND;
        end
        if (r < 25)
        begin
            return LENGTH_W'($urandom_range(1, int'(LEN_BOUND)));
        end
        if (r < 35)
        begin
            return LENGTH_W'(BLOCK_SIZE * $urandom_range(1, 3));
        end
        return LENGTH_W'($urandom_range(1, 3 * BLOCK_SIZE));
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.start_offset <= '0;
            req_ch.length       <= '0;
            request_gap         <= 0;
        end
        else if (!req_ch.valid || request_taken)
        begin
            if (request_gap > 0)
            begin
                request_gap  <= request_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                req_ch.start_offset <= pending_requests[0].start_offset;
                req_ch.length       <= pending_requests[0].length;
                req_ch.valid        <= 1'b1;
                void'(pending_requests.pop_front());
                request_gap <= steady ? 0 : pick_gap();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // chunk receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            chunk_ch.ready <= 1'b0;
            chunk_stall    <= 0;
        end
        else if (chunk_stall > 0)
        begin
            chunk_stall    <= chunk_stall - 1;
            chunk_ch.ready <= 1'b0;
        end
        else
        begin
            chunk_ch.ready <= 1'b1;
            chunk_stall    <= steady ? 0 : pick_gap();
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : monitor
        chunk_t want;
        if (!rst_n)
        begin
            request_taken    <= 1'b0;
            device_count_cfg = DEV_CNT_W'(1);
        end
        else
        begin
            request_taken <= req_ch.valid && req_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                device_count_cfg = cfg_ch.device_count;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                split_request(req_ch.start_offset, req_ch.length);
            end
            if (chunk_ch.valid && chunk_ch.ready)
            begin
                if (expected_chunks.size() == 0)
                begin
                    report_mismatch("chunk with no request pending");
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    check_field("device_index", 64'(chunk_ch.device_index), 64'(want.device_index));
                    check_field("device_offset", 64'(chunk_ch.device_offset),
                                64'(want.device_offset));
                    check_field("chunk_length", 64'(chunk_ch.chunk_length), 64'(want.chunk_length));
                    check_field("request_offset", 64'(chunk_ch.request_offset),
                                64'(want.request_offset));
                    check_field("last_chunk", 64'(chunk_ch.last_chunk), 64'(want.last_chunk));
                    check_field("error", 64'(chunk_ch.error), 64'(want.error));
                end
            end
        end
    end

    task automatic write_device_count(input logic [DEV_CNT_W-1:0] value);
        @(negedge clk);
        cfg_ch.device_count <= value;
        cfg_ch.valid        <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_chunks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [DEV_CNT_W-1:0] phase_counts[11];
        phase_counts = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd7, 5'd17, 5'd5, 5'd2, 5'd12, 5'd9};
        steady              = 1'b0;
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.device_count = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests at the reset device count
        queue_request(48'h0, 22'd1);
        queue_request(48'h0, 22'd0);
        queue_request(48'h0, LENGTH_W'(BLOCK_SIZE));
        queue_request(48'h0, LEN_BOUND);
        queue_request(48'h1, LEN_BOUND);
        queue_request(48'hFFFF, 22'd2);
        queue_request(48'hFFFF_FFFF_FFFF, 22'd1);
        queue_request(48'hFFFF_FFFF_FFFF - 48'd99, 22'd70000);
        queue_request(48'h0, LEN_BOUND + 22'd1);
        queue_request(48'h1234_5678_9ABC, 22'h3FFFFF);
        queue_request(48'hAAAA_AAAA_AAAA, 22'h155555);
        queue_request(48'h5555_5555_5555, 22'h2AAAAA);
        queue_request(48'hFFFF_FFFF_0000, LEN_BOUND);
        drain();

        foreach (phase_counts[p])
        begin
            write_device_count(phase_counts[p]);
            steady = ($urandom_range(0, 3) == 0);
            if (p == 0)
            begin
                queue_request(48'h000F_0000, LENGTH_W'(16 * BLOCK_SIZE));
                queue_request(48'hFFFF_FFFF_FFFF - 48'd99, 22'd70000);
            end
            repeat (34)
            begin
                queue_request(random_start(), random_length());
            end
            drain();
        end

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
